/* hw/rtl/rot3d_pkg.sv */
// Shared types, axis codes and CORDIC constants for the 3D axis rotator.
// No dependencies; imported by rotate_point_about_axis_3d_top and its testbench.
package rot3d_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int COORD_BITS_DEF    = 32;

	localparam int FIELD_W  = 32;
	localparam int OP_W     = 2;
	localparam int IN_DATA_W  = 4 * FIELD_W;
	localparam int OUT_DATA_W = 3 * FIELD_W;

	// prescaled coordinate, CORDIC datapath, residual angle, rounded result
	localparam int PRE_W  = 48;
	localparam int CORD_W = 52;
	localparam int RES_W  = 34;
	localparam int GUARD  = 16;
	localparam int RND_W  = CORD_W - GUARD;
	localparam int MAX_STAGES = 32;

	typedef logic [OP_W-1:0] axis_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	// 1/K in Q0.32
	localparam logic signed [FIELD_W:0] GAIN_INV = 33'sh0_9B74_EDA8;

	localparam logic [FIELD_W-1:0] ATAN_TAB [MAX_STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

/* hw/rtl/rotate_point_about_axis_3d_top.sv */
// Pipelined CORDIC rotation of a Q16.16 point about the x, y or z axis.
// Depends on rot3d_pkg for codes, widths and the arctangent table.
//
// Channel  Dir  Fields (tdata/tuser, lowest bit first)
// s_axis   in   tuser: op ; tdata: px, py, pz, angle
// m_axis   out  tdata: rx, ry, rz
//
// The stages are multiply, round, quadrant fold, one CORDIC iteration per stage,
// then round and saturate into the output register. One point enters per cycle
// unless the pipeline is stalled. Each stage holds only while it is full and the
// stage after it is stalled, so bubbles are squeezed out under backpressure.
// Reset clears the valid bits only.
module rotate_point_about_axis_3d_top #(
	parameter int CORDIC_STAGES = rot3d_pkg::CORDIC_STAGES_DEF,
	parameter int COORD_BITS    = rot3d_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// px[31:0], py[63:32], pz[95:64], angle[127:96]
	input  logic [rot3d_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// op[1:0]
	input  logic [rot3d_pkg::OP_W-1:0]          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// rx[31:0], ry[63:32], rz[95:64]
	output logic [rot3d_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import rot3d_pkg::*;

	localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int SAT_BITS = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

	function automatic logic [FIELD_W-1:0] sat(input logic signed [RND_W-1:0] r);
		logic signed [RND_W-1:0] c;
		begin
			if (r > SAT_HI) begin
				c = SAT_HI;
			end else if (r < SAT_LO) begin
				c = SAT_LO;
			end else begin
				c = r;
			end
			sat = c[FIELD_W-1:0];
		end
	endfunction

	logic signed [FIELD_W-1:0] in_px, in_py, in_pz;
	logic        [FIELD_W-1:0] in_ang;
	logic signed [FIELD_W-1:0] sel_u, sel_v, sel_p;
	logic signed [63:0]        mul_u, mul_v;

	assign in_px  = s_axis_tdata[FIELD_W-1:0];
	assign in_py  = s_axis_tdata[2*FIELD_W-1:FIELD_W];
	assign in_pz  = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
	assign in_ang = s_axis_tdata[4*FIELD_W-1:3*FIELD_W];

	always_comb begin
		case (s_axis_tuser)
			AXIS_X: begin
				sel_u = in_py;
				sel_v = in_pz;
				sel_p = in_px;
			end
			AXIS_Y: begin
				sel_u = in_pz;
				sel_v = in_px;
				sel_p = in_py;
			end
			default: begin
				sel_u = in_px;
				sel_v = in_py;
				sel_p = in_pz;
			end
		endcase
	end

	assign mul_u = 64'(sel_u) * 64'(GAIN_INV);
	assign mul_v = 64'(sel_v) * 64'(GAIN_INV);

	// stage 1: prescale products
	logic                      v_s1;
	logic signed [63:0]        pu_s1, pv_s1;
	logic signed [FIELD_W-1:0] pass_s1;
	logic        [FIELD_W-1:0] ang_s1;
	axis_t                     op_s1;

	// stage 2: rounded prescaled coordinates
	logic                      v_s2;
	logic signed [PRE_W-1:0]   wu_s2, wv_s2;
	logic signed [FIELD_W-1:0] pass_s2;
	logic        [FIELD_W-1:0] ang_s2;
	axis_t                     op_s2;

	// stage 3+k: fold at k = 0, then k CORDIC iterations done
	logic                      vk_sk   [0:NS];
	logic signed [CORD_W-1:0]  cu_sk   [0:NS];
	logic signed [CORD_W-1:0]  cv_sk   [0:NS];
	logic signed [RES_W-1:0]   res_sk  [0:NS];
	logic signed [FIELD_W-1:0] pass_sk [0:NS];
	axis_t                     op_sk   [0:NS];

	logic                      vld_out_q;
	logic [FIELD_W-1:0]        rx_q, ry_q, rz_q;

	logic                      en_s1, en_s2, en_out;
	logic [NS:0]               en_k;

	assign en_out = !vld_out_q || m_axis_tready;

	for (genvar k = 0; k <= NS; k++) begin : g_en
		if (k == NS) begin : g_last
			assign en_k[k] = !vk_sk[k] || en_out;
		end else begin : g_mid
			assign en_k[k] = !vk_sk[k] || en_k[k+1];
		end
	end

	assign en_s2 = !v_s2 || en_k[0];
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vld_out_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_out) vld_out_q <= vk_sk[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pu_s1   <= mul_u;
			pv_s1   <= mul_v;
			pass_s1 <= sel_p;
			ang_s1  <= in_ang;
			op_s1   <= s_axis_tuser;
		end
		if (en_s2) begin
			wu_s2   <= PRE_W'((pu_s1 + 64'sd32768) >>> GUARD);
			wv_s2   <= PRE_W'((pv_s1 + 64'sd32768) >>> GUARD);
			pass_s2 <= pass_s1;
			ang_s2  <= ang_s1;
			op_s2   <= op_s1;
		end
	end

	// quadrant fold: negate the pair and add a half turn outside +-90 degrees
	logic                     fold;
	logic [FIELD_W-1:0]       ang_fold;
	logic signed [CORD_W-1:0] wu_ext, wv_ext;

	assign fold     = ang_s2[FIELD_W-1] ^ ang_s2[FIELD_W-2];
	assign ang_fold = ang_s2 + {fold, {(FIELD_W-1){1'b0}}};
	assign wu_ext   = CORD_W'(wu_s2);
	assign wv_ext   = CORD_W'(wv_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vk_sk[0] <= 1'b0;
		end else if (en_k[0]) begin
			vk_sk[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_k[0]) begin
			cu_sk[0]   <= fold ? -wu_ext : wu_ext;
			cv_sk[0]   <= fold ? -wv_ext : wv_ext;
			res_sk[0]  <= RES_W'($signed(ang_fold));
			pass_sk[0] <= pass_s2;
			op_sk[0]   <= op_s2;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_cordic
		localparam logic signed [RES_W-1:0] ATAN_K = RES_W'(ATAN_TAB[k]);
		logic signed [CORD_W-1:0] du, dv;

		assign du = cv_sk[k] >>> k;
		assign dv = cu_sk[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vk_sk[k+1] <= 1'b0;
			end else if (en_k[k+1]) begin
				vk_sk[k+1] <= vk_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en_k[k+1]) begin
				if (!res_sk[k][RES_W-1]) begin
					cu_sk[k+1]  <= cu_sk[k] - du;
					cv_sk[k+1]  <= cv_sk[k] + dv;
					res_sk[k+1] <= res_sk[k] - ATAN_K;
				end else begin
					cu_sk[k+1]  <= cu_sk[k] + du;
					cv_sk[k+1]  <= cv_sk[k] - dv;
					res_sk[k+1] <= res_sk[k] + ATAN_K;
				end
				pass_sk[k+1] <= pass_sk[k];
				op_sk[k+1]   <= op_sk[k];
			end
		end
	end

	// round off the guard bits, saturate and map back to x, y, z
	logic signed [CORD_W-1:0] ru_full, rv_full;
	logic [FIELD_W-1:0]       su, sv, sp;

	assign ru_full = (cu_sk[NS] + CORD_W'(32768)) >>> GUARD;
	assign rv_full = (cv_sk[NS] + CORD_W'(32768)) >>> GUARD;
	assign su = sat(ru_full[RND_W-1:0]);
	assign sv = sat(rv_full[RND_W-1:0]);
	assign sp = sat(RND_W'(pass_sk[NS]));

	always_ff @(posedge clk) begin
		if (en_out) begin
			case (op_sk[NS])
				AXIS_X: begin
					rx_q <= sp;
					ry_q <= su;
					rz_q <= sv;
				end
				AXIS_Y: begin
					rx_q <= sv;
					ry_q <= sp;
					rz_q <= su;
				end
				default: begin
					rx_q <= su;
					ry_q <= sv;
					rz_q <= sp;
				end
			endcase
		end
	end

	assign m_axis_tvalid = vld_out_q;
	assign m_axis_tdata  = {rz_q, ry_q, rx_q};

endmodule

/* dv/rotate_point_about_axis_3d_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for rotate_point_about_axis_3d_top: streams Q16.16 points, predicts each
// rotated point with a bit-exact CORDIC model and checks every output transfer.
// Depends on rot3d_pkg and the rotator top level.
module rotate_point_about_axis_3d_top_tb;
	import rot3d_pkg::*;

	localparam int STAGES      = CORDIC_STAGES_DEF;
	localparam int COORD_BITS  = COORD_BITS_DEF;
	localparam int LATENCY     = ((STAGES < 32) ? STAGES : 32) + 4;
	localparam int CYCLE_LIMIT = 200000;

	localparam int SAT_BITS_RAW = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int SAT_BITS     = (SAT_BITS_RAW < 2) ? 2 : SAT_BITS_RAW;
	localparam longint SAT_HI   = (64'sd1 <<< (SAT_BITS - 1)) - 1;
	localparam longint SAT_LO   = -SAT_HI - 1;

	localparam longint GAIN_INV_Q32 = 64'sd2608131496;
	localparam int     GUARD_SHIFT  = 16;
	localparam longint GUARD_HALF   = 64'sd32768;

	localparam axis_t AXIS_Z_ALIAS = 2'd3;

	localparam logic [31:0] COORD_MAX    = 32'h7FFF_FFFF;
	localparam logic [31:0] COORD_MIN    = 32'h8000_0000;
	localparam logic [31:0] Q_ONE        = 32'h0001_0000;
	localparam logic [31:0] TURN_EIGHTH  = 32'h2000_0000;
	localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [31:0] TURN_HALF    = 32'h8000_0000;

	localparam logic [31:0] ARCTAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic [31:0] rz;
		logic [31:0] ry;
		logic [31:0] rx;
	} rotated_point_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [OP_W-1:0]       s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	rotated_point_t expected_points [$];
	int  fail_count   = 0;
	int  points_sent  = 0;
	int  points_seen  = 0;
	int  cycle_count  = 0;
	int  stall_left   = 0;
	bit  src_idle_en  = 1'b1;
	bit  sink_idle_en = 1'b1;

	rotate_point_about_axis_3d_top #(
		.CORDIC_STAGES(STAGES),
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),    // px, py, pz, angle
		.s_axis_tuser(s_axis_tuser),    // op
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)     // rx, ry, rz
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] clamp_coord(input longint w, input bit guarded);
		longint r;
		r = guarded ? ((w + GUARD_HALF) >>> GUARD_SHIFT) : w;
		if (r > SAT_HI)
			r = SAT_HI;
		if (r < SAT_LO)
			r = SAT_LO;
		return r[31:0];
	endfunction

	function automatic rotated_point_t rotate_point(input axis_t op, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] pz, input logic [31:0] angle);
		longint x, y, z, u, v, du, dv, res;
		logic [31:0] a;
		rotated_point_t r;
		x = longint'($signed(px));
		y = longint'($signed(py));
		z = longint'($signed(pz));
		case (op)
			AXIS_X: begin
				u = y;
				v = z;
			end
			AXIS_Y: begin
				u = z;
				v = x;
			end
			default: begin
				u = x;
				v = y;
			end
		endcase
		u = (u * GAIN_INV_Q32 + GUARD_HALF) >>> GUARD_SHIFT;
		v = (v * GAIN_INV_Q32 + GUARD_HALF) >>> GUARD_SHIFT;
		// fold into the right half-plane
		a = angle;
		if (a[31] ^ a[30]) begin
			u = -u;
			v = -v;
			a = a + TURN_HALF;
		end
		res = longint'($signed(a));
		for (int i = 0; i < STAGES && i < 32; i++) begin
			du = v >>> i;
			dv = u >>> i;
			if (res >= 0) begin
				u = u - du;
				v = v + dv;
				res = res - longint'(ARCTAN_TURNS[i]);
			end else begin
				u = u + du;
				v = v - dv;
				res = res + longint'(ARCTAN_TURNS[i]);
			end
		end
		case (op)
			AXIS_X: begin
				r.rx = clamp_coord(x, 1'b0);
				r.ry = clamp_coord(u, 1'b1);
				r.rz = clamp_coord(v, 1'b1);
			end
			AXIS_Y: begin
				r.rx = clamp_coord(v, 1'b1);
				r.ry = clamp_coord(y, 1'b0);
				r.rz = clamp_coord(u, 1'b1);
			end
			default: begin
				r.rx = clamp_coord(u, 1'b1);
				r.ry = clamp_coord(v, 1'b1);
				r.rz = clamp_coord(z, 1'b0);
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
			6, 7:       return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
			8:          return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			default:    return $urandom_range(0, 4) - 2;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic send_point(input axis_t op, input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [31:0] angle);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {angle, pz, py, px};
		do
			@(posedge clk);
		while (!s_axis_tready);
		points_sent++;
	endtask

	// predict on input transfer, check on output transfer
	always @(posedge clk) begin
		rotated_point_t exp_p, act_p;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_points.push_back(rotate_point(s_axis_tuser, s_axis_tdata[31:0],
				s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[127:96]));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			act_p = m_axis_tdata;
			points_seen++;
			if (expected_points.size() == 0) begin
				$error("output transfer with no point pending: %h", m_axis_tdata);
				fail_count++;
			end else begin
				exp_p = expected_points.pop_front();
				check_field("rx", exp_p.rx, act_p.rx);
				check_field("ry", exp_p.ry, act_p.ry);
				check_field("rz", exp_p.rz, act_p.rz);
			end
		end
	end

	always @(posedge clk) begin
		if (!sink_idle_en) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left = $urandom_range(0, 6);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_axis_codes();
		send_point(AXIS_X, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, TURN_QUARTER);
		send_point(AXIS_Y, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, TURN_QUARTER);
		send_point(AXIS_Z, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, TURN_QUARTER);
		send_point(AXIS_Z_ALIAS, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, TURN_QUARTER);
	endtask

	task automatic test_field_extremes();
		send_point(AXIS_Z, 32'h0, 32'h0, 32'h0, 32'h0);
		send_point(AXIS_Z, COORD_MAX, COORD_MIN, COORD_MAX, 32'h0);
		send_point(AXIS_X, COORD_MIN, COORD_MAX, COORD_MIN, TURN_HALF);
		send_point(AXIS_Y, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_point(AXIS_Z, Q_ONE, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_point(AXIS_X, 32'h0, Q_ONE, 32'h0, 32'hC000_0000);
		send_point(AXIS_Y, 32'h0, 32'h0, Q_ONE, 32'h3FFF_FFFF);
		send_point(AXIS_Z_ALIAS, COORD_MIN, COORD_MIN, COORD_MIN, 32'h8000_0001);
		send_point(AXIS_Z, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h4000_0001);
		send_point(AXIS_X, COORD_MAX, COORD_MAX, COORD_MAX, 32'hBFFF_FFFF);
	endtask

	task automatic test_saturation();
		send_point(AXIS_Z, COORD_MAX, COORD_MAX, COORD_MIN, TURN_EIGHTH);
		send_point(AXIS_Z, COORD_MAX, COORD_MAX, COORD_MAX, -TURN_EIGHTH);
		send_point(AXIS_X, COORD_MIN, COORD_MIN, COORD_MIN, TURN_EIGHTH);
		send_point(AXIS_Y, COORD_MIN, COORD_MAX, COORD_MIN, -TURN_EIGHTH);
		send_point(AXIS_Y, COORD_MAX, COORD_MIN, COORD_MAX, TURN_EIGHTH);
		send_point(AXIS_X, COORD_MAX, COORD_MIN, COORD_MAX, 32'hA000_0000);
	endtask

	task automatic test_random_points(input int count, input bit with_idling);
		logic [31:0] angle;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				src_idle_en  = with_idling && ($urandom_range(0, 3) != 0);
				sink_idle_en = with_idling && ($urandom_range(0, 3) != 0);
			end
			// bias some angles onto the quadrant boundaries
			if ($urandom_range(0, 3) == 0)
				angle = ($urandom_range(0, 3) << 30) + $urandom_range(0, 64) - 32;
			else
				angle = $urandom;
			send_point(axis_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
				rand_coord(), angle);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_axis_codes();
		test_field_extremes();
		test_saturation();
		test_random_points(1200, 1'b1);
		test_random_points(300, 1'b0);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (expected_points.size() != 0) begin
			$error("%0d points never came out", expected_points.size());
			fail_count++;
		end
		$display("Rotated %0d points (%0d checked) about all axis codes, with field extremes,",
			points_sent, points_seen);
		$display("saturating cases, random stalls on both sides and a back-to-back stretch.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/rot3d_pkg.sv
hw/rtl/rotate_point_about_axis_3d_top.sv
dv/rotate_point_about_axis_3d_top_tb.sv
